/* design/adjacency_matrix_graph_store_macros.svh */
// assertion macros used by the checker file
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH

// same-cycle implication, muted during reset
`define AMGS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, muted during reset
`define AMGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* design/amgs_pkg.sv */
// constants, types and helpers for the adjacency matrix graph store
`timescale 1ns / 1ps

package amgs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 32;

  localparam int VTX_BITS   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int COUNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH      = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_BITS  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_TEST   = 3'd3,
    REQ_LIST   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_REJECT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIRROR,
    ST_TEST_WAIT,
    ST_EMIT,
    ST_LIST,
    ST_LIST_END
  } state_t;

  // row-major position of an entry in the weight memory
  function automatic logic [ADDR_BITS-1:0] mat_addr(input logic [VTX_BITS-1:0] r,
                                                    input logic [VTX_BITS-1:0] c);
    return ADDR_BITS'(ADDR_BITS'(r) * ADDR_BITS'(MAX_VERTICES) + ADDR_BITS'(c));
  endfunction

endpackage

/* design/adjacency_matrix_graph_store.sv */
// weighted adjacency matrix graph store: request decoder, row scanner and weight memory
//
//   port group   dir  handshake          contents
//   s_*          in   s_tvalid/s_tready  request word: vertices and weight, kind in tuser
//   m_*          out  m_tvalid/m_tready  result word: neighbour, weight, count; flags in tuser
//   cfg_*        in   cfg_valid/cfg_ready directed_mode bit
//
// after reset and after every clear the memory is swept, one entry a cycle, DEPTH (4096)
// entries in all; no request is taken during the sweep, and a clear answers at its end.
// add/delete go to ST_EMIT, undirected via ST_MIRROR (the mirror is a second write).
// test goes to ST_TEST_WAIT for the synchronous memory read, then to ST_EMIT.
// a listing reads one column a cycle from the memory port, unless the result register
// is held by m_tready low.
// a request is taken whenever the block is idle, even with a result still waiting.
`timescale 1ns / 1ps

module adjacency_matrix_graph_store import amgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // from_vertex[9:0], to_vertex[19:10], edge_weight[51:20]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // neighbour_vertex[5:0], neighbour_weight[37:6],
                                 // vertex_total[44:38]
  output logic [2:0]  m_tuser,   // found[0], status[2:1]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  state_t state, state_next;

  // weight memory
  logic signed [WEIGHT_BITS-1:0] mem [0:DEPTH-1];
  logic signed [WEIGHT_BITS-1:0] rdata;
  logic                          mem_we, mem_re;
  logic [ADDR_BITS-1:0]          mem_waddr, mem_raddr;
  logic signed [WEIGHT_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // control and payload registers
  logic [ADDR_BITS-1:0]          clr_addr;
  logic                          clr_reply;
  logic [COUNT_BITS-1:0]         vertex_count;
  logic                          directed;
  logic [ADDR_BITS-1:0]          mirror_addr;
  logic signed [WEIGHT_BITS-1:0] mirror_data;
  logic signed [WEIGHT_BITS-1:0] res_weight;
  logic                          res_found;
  status_t                       res_status;
  logic [VTX_BITS-1:0]           row;
  logic [COUNT_BITS-1:0]         col_iss;
  logic [VTX_BITS-1:0]           col_chk;
  logic                          chk_valid;
  logic                          pend_valid;
  logic [VTX_BITS-1:0]           pend_col;
  logic signed [WEIGHT_BITS-1:0] pend_weight;

  logic                          out_valid;
  logic [5:0]                    out_vertex;
  logic signed [31:0]            out_weight;
  logic                          out_found;
  status_t                       out_status;
  logic [6:0]                    out_total;
  logic                          out_last;

  // input word
  req_t                 in_req;
  logic [9:0]           in_from, in_to, in_max;
  logic signed [31:0]   in_weight;
  logic signed [WEIGHT_BITS-1:0] in_wfit;
  logic                 cap_ok, from_in, to_in;
  logic [COUNT_BITS-1:0] count_grow;
  logic                 acc, out_free;

  assign in_req    = req_t'(s_tuser);
  assign in_from   = s_tdata[9:0];
  assign in_to     = s_tdata[19:10];
  assign in_weight = s_tdata[51:20];
  assign in_wfit   = WEIGHT_BITS'(in_weight);
  assign cap_ok    = (11'(in_from) < 11'(MAX_VERTICES)) && (11'(in_to) < 11'(MAX_VERTICES));
  assign from_in   = 11'(in_from) < 11'(vertex_count);
  assign to_in     = 11'(in_to) < 11'(vertex_count);
  assign in_max    = (in_from > in_to) ? in_from : in_to;
  assign count_grow = COUNT_BITS'(11'(in_max) + 11'd1);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  // listing scan: column in rdata is col_chk when chk_valid
  logic hit, list_stall, list_go, list_issue;
  assign hit        = chk_valid && (rdata != '0);
  assign list_stall = hit && pend_valid && !out_free;
  assign list_go    = (state == ST_LIST) && !list_stall;
  assign list_issue = list_go && (col_iss < vertex_count);

  // loads into the result register
  logic                 out_load;
  logic [VTX_BITS-1:0]  ld_vertex;
  logic signed [WEIGHT_BITS-1:0] ld_weight;
  logic                 ld_found, ld_last;
  status_t              ld_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = mat_addr(row, col_iss[VTX_BITS-1:0]);
    out_load   = 1'b0;
    ld_vertex  = '0;
    ld_weight  = '0;
    ld_found   = 1'b0;
    ld_status  = STAT_DONE;
    ld_last    = 1'b1;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == ADDR_BITS'(DEPTH - 1)) begin
          state_next = clr_reply ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EMIT;
          case (in_req)
            REQ_CLEAR: begin
              state_next = ST_CLEAR;
            end
            REQ_ADD: begin
              if (cap_ok) begin
                mem_we    = 1'b1;
                mem_waddr = mat_addr(VTX_BITS'(in_from), VTX_BITS'(in_to));
                mem_wdata = in_wfit;
                if (!directed) begin
                  state_next = ST_MIRROR;
                end
              end
            end
            REQ_DELETE: begin
              if (from_in && to_in) begin
                mem_we    = 1'b1;
                mem_waddr = mat_addr(VTX_BITS'(in_from), VTX_BITS'(in_to));
                if (!directed) begin
                  state_next = ST_MIRROR;
                end
              end
            end
            REQ_TEST: begin
              if (from_in && to_in) begin
                mem_re     = 1'b1;
                mem_raddr  = mat_addr(VTX_BITS'(in_from), VTX_BITS'(in_to));
                state_next = ST_TEST_WAIT;
              end
            end
            REQ_LIST: begin
              if (from_in) begin
                state_next = ST_LIST;
              end
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_MIRROR: begin
        mem_we     = 1'b1;
        mem_waddr  = mirror_addr;
        mem_wdata  = mirror_data;
        state_next = ST_EMIT;
      end
      ST_TEST_WAIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_weight  = res_weight;
          ld_found   = res_found;
          ld_status  = res_status;
          state_next = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (!list_stall) begin
          // a new hit pushes the held one out; the held one is last only at the end
          if (hit && pend_valid) begin
            out_load  = 1'b1;
            ld_vertex = pend_col;
            ld_weight = pend_weight;
            ld_found  = 1'b1;
            ld_last   = 1'b0;
          end
          if (list_issue) begin
            mem_re = 1'b1;
          end else if (!chk_valid) begin
            state_next = ST_LIST_END;
          end
        end
      end
      ST_LIST_END: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_vertex  = pend_valid ? pend_col : '0;
          ld_weight  = pend_valid ? pend_weight : '0;
          ld_found   = pend_valid;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      vertex_count <= '0;
      directed     <= 1'b0;
      out_valid    <= 1'b0;
      chk_valid    <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        directed <= cfg_data;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (state == ST_CLEAR) begin
        clr_addr <= (clr_addr == ADDR_BITS'(DEPTH - 1)) ? '0 : clr_addr + 1'b1;
      end

      if (acc) begin
        res_weight <= '0;
        res_found  <= 1'b0;
        res_status <= STAT_DONE;
        case (in_req)
          REQ_CLEAR: begin
            vertex_count <= '0;
            clr_reply    <= 1'b1;
          end
          REQ_ADD: begin
            if (!cap_ok) begin
              res_status <= STAT_REJECT;
            end else if (!(from_in && to_in)) begin
              vertex_count <= count_grow;
            end
          end
          REQ_DELETE, REQ_TEST: begin
            if (!(from_in && to_in)) begin
              res_status <= STAT_IGNORED;
            end
          end
          REQ_LIST: begin
            if (!from_in) begin
              res_status <= STAT_IGNORED;
            end
          end
          default: begin
            res_status <= STAT_DONE;
          end
        endcase
        mirror_addr <= mat_addr(VTX_BITS'(in_to), VTX_BITS'(in_from));
        mirror_data <= (in_req == REQ_ADD) ? in_wfit : '0;
        row         <= VTX_BITS'(in_from);
        col_iss     <= '0;
        chk_valid   <= 1'b0;
        pend_valid  <= 1'b0;
      end

      if (state == ST_TEST_WAIT) begin
        res_weight <= rdata;
        res_found  <= (rdata != '0);
      end

      if (list_go) begin
        if (hit) begin
          pend_valid  <= 1'b1;
          pend_col    <= col_chk;
          pend_weight <= rdata;
        end
        if (list_issue) begin
          col_chk   <= col_iss[VTX_BITS-1:0];
          col_iss   <= col_iss + 1'b1;
          chk_valid <= 1'b1;
        end else begin
          chk_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex <= 6'(ld_vertex);
      out_weight <= 32'(ld_weight);
      out_found  <= ld_found;
      out_status <= ld_status;
      out_total  <= 7'(vertex_count);
      out_last   <= ld_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_total, out_weight, out_vertex};
  assign m_tuser  = {out_status, out_found};
  assign m_tlast  = out_last;

endmodule

/* design/amgs_checker.sv */
// port-level checks for the adjacency matrix graph store, bound to the top level
`timescale 1ns / 1ps
`include "adjacency_matrix_graph_store_macros.svh"

module amgs_checker import amgs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result word holds
  `AMGS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // only a listing gives more than one word, and those all carry a neighbour
  `AMGS_ASSERT_NOW(a_mid_found, clk, rst, m_tvalid && !m_tlast, m_tuser[0] && m_tuser[2:1] == STAT_DONE)

  // ignored or rejected requests report nothing found and no weight
  `AMGS_ASSERT_NOW(a_fail_empty, clk, rst, m_tvalid && m_tuser[2:1] != STAT_DONE, !m_tuser[0] && m_tdata[37:6] == 32'd0 && m_tlast)

  // the code that has no meaning never shows
  `AMGS_ASSERT_NOW(a_status_code, clk, rst, m_tvalid, m_tuser[2:1] != 2'd3)

  // the vertex count never exceeds capacity
  `AMGS_ASSERT_NOW(a_total_cap, clk, rst, m_tvalid, m_tdata[44:38] <= 7'(MAX_VERTICES))

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (.*);
